// ===== src/adm_pkg.sv =====
`timescale 1ns / 1ps
// package for the adjacency matrix dfs block: request/response payload types,
// command codes and register constants. no dependencies.
package adm_pkg;

  // command codes carried in the request
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
  localparam logic [1:0] CMD_VISIT    = 2'd2;

  // vertex_count register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] VCOUNT_RST = 5'd16;

  // width of vertex fields on the ports
  localparam int unsigned VTX_W = 4;

  typedef struct packed {
    logic [1:0]       command;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } adm_req_t;

  typedef struct packed {
    logic [VTX_W-1:0] visited_vertex;
    logic             last;
  } adm_rsp_t;

endpackage

// ===== src/adm_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data.
// no dependencies.
module adm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/adm_pri_enc.sv =====
`timescale 1ns / 1ps
// lowest-set-bit priority encoder used to pick the next neighbor.
// no dependencies.
module adm_pri_enc #(
  parameter int unsigned WIDTH = 16
) (
  input  logic [WIDTH-1:0]         vec_i,
  output logic [$clog2(WIDTH)-1:0] idx_o,
  output logic                     found_o
);

  always_comb begin
    idx_o = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = ($clog2(WIDTH))'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

// ===== src/adjacency_matrix_dfs_top.sv =====
`timescale 1ns / 1ps
// top level of the adjacency matrix dfs block: sequencer, adjacency and stack
// rams, visited set and response register. uses adm_pkg, adm_ram, adm_pri_enc.
//
// The block keeps an undirected graph of up to MAX_VERTICES vertices as a bit
// matrix in a ram (one row per vertex, a valid bit per row so that reset and
// the clear command empty it without a ram write). A clear request only drops
// the row valid bits, an add-edge request does a read-modify-write of both
// rows. A visit request walks the graph depth first from vertex_a, lowest
// neighbor first, and returns one response per vertex reached in preorder,
// the final one flagged with last. The walk runs on one adjacency read port
// and one priority encoder: the accepting cycle issues the first row read,
// each newly reached vertex after the start is taken by a scan that returns
// the pending vertex (held while the response side stalls), each backtrack
// is a failed scan that issues the stack ram read, then the row read, and the
// final failed scan at the start vertex leads to flushing the last response.
// req_stall_o stays high from acceptance until the request is finished; the
// response register lets the next request be accepted while the last
// response still waits to be taken.
// vertex_count may be written at any time the block is idle; values above
// MAX_VERTICES act as MAX_VERTICES.
module adjacency_matrix_dfs_top #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  adm_pkg::adm_req_t          req_i,
  // response channel
  output logic                       rsp_valid_o,
  input  logic                       rsp_stall_i,
  output adm_pkg::adm_rsp_t          rsp_o,
  // vertex_count register
  input  logic                       cfg_we_i,
  input  logic [adm_pkg::CFG_W-1:0]  cfg_wdata_i
);

  import adm_pkg::*;

  localparam int unsigned N  = MAX_VERTICES;
  localparam int unsigned VW = $clog2(N);      // vertex index width
  localparam int unsigned SW = $clog2(N + 1);  // stack depth counter width
  localparam int unsigned CW = $clog2(N + 1);  // effective count width

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_SCAN,
    ST_POP,
    ST_FLUSH
  } state_e;

  // sequencer state
  state_e          state_q, state_d;
  logic [CFG_W-1:0] vcount_q, vcount_d;
  logic [N-1:0]    row_vld_q, row_vld_d;   // adjacency row holds data
  logic            rd_vld_q, rd_vld_d;     // valid bit of the row being read
  logic [N-1:0]    visited_q, visited_d;
  logic [VW-1:0]   a_q, a_d;
  logic [VW-1:0]   b_q, b_d;
  logic [VW-1:0]   top_q, top_d;           // vertex on top of the walk stack
  logic [VW-1:0]   pend_q, pend_d;         // reached vertex not yet returned
  logic [SW-1:0]   sp_q, sp_d;             // entries held in the stack ram
  logic            rsp_valid_q, rsp_valid_d;
  adm_rsp_t        rsp_q, rsp_d;

  // ram ports
  logic            adj_we;
  logic [VW-1:0]   adj_waddr, adj_raddr;
  logic [N-1:0]    adj_wdata, adj_rdata;
  logic            stk_we;
  logic [VW-1:0]   stk_waddr, stk_raddr;
  logic [VW-1:0]   stk_rdata;

  // walk datapath
  logic [CW-1:0]   n_eff;
  logic [N-1:0]    act_mask;
  logic [N-1:0]    row;
  logic [N-1:0]    cand;
  logic [VW-1:0]   nxt;
  logic            found;
  logic            req_acc;
  logic            out_free;
  logic            a_ok, b_ok;
  logic [VW-1:0]   in_a, in_b;

  adm_ram #(
    .WIDTH (N),
    .DEPTH (N)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  adm_ram #(
    .WIDTH (VW),
    .DEPTH (N)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (top_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  adm_pri_enc #(
    .WIDTH (N)
  ) u_pri_enc (
    .vec_i   (cand),
    .idx_o   (nxt),
    .found_o (found)
  );

  // count in use saturates at the matrix size
  always_comb begin
    if (32'(vcount_q) > N) begin
      n_eff = CW'(N);
    end else begin
      n_eff = CW'(vcount_q);
    end
    for (int i = 0; i < N; i++) begin
      act_mask[i] = (i < int'(n_eff));
    end
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign req_acc     = req_valid_i && !req_stall_o;
  assign out_free    = !rsp_valid_q || !rsp_stall_i;

  assign in_a = VW'(req_i.vertex_a);
  assign in_b = VW'(req_i.vertex_b);
  assign a_ok = (32'(req_i.vertex_a) < 32'(n_eff));
  assign b_ok = (32'(req_i.vertex_b) < 32'(n_eff));

  // row of the vertex read last cycle, minus used-up and out-of-range bits
  assign row  = rd_vld_q ? adj_rdata : '0;
  assign cand = row & act_mask & ~visited_q;

  assign stk_waddr = sp_q[VW-1:0];
  assign stk_raddr = VW'(sp_q - SW'(1));

  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    row_vld_d   = row_vld_q;
    visited_d   = visited_q;
    a_d         = a_q;
    b_d         = b_q;
    top_d       = top_q;
    pend_d      = pend_q;
    sp_d        = sp_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d       = rsp_q;
    adj_we      = 1'b0;
    adj_waddr   = a_q;
    adj_wdata   = row | (N'(1) << b_q);
    adj_raddr   = top_q;
    stk_we      = 1'b0;

    if (cfg_we_i) begin
      vcount_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        adj_raddr = in_a;
        if (req_acc) begin
          a_d = in_a;
          b_d = in_b;
          case (req_i.command)
            CMD_CLEAR: begin
              row_vld_d = '0;
            end
            CMD_ADD_EDGE: begin
              if (a_ok && b_ok) begin
                state_d = ST_ADD_A;
              end
            end
            CMD_VISIT: begin
              if (a_ok) begin
                visited_d = N'(1) << in_a;
                top_d     = in_a;
                pend_d    = in_a;
                sp_d      = '0;
                state_d   = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // row a is on the read port: set bit b, start reading row b
      ST_ADD_A: begin
        adj_we           = 1'b1;
        adj_waddr        = a_q;
        adj_wdata        = row | (N'(1) << b_q);
        row_vld_d[a_q]   = 1'b1;
        adj_raddr        = b_q;
        state_d          = ST_ADD_B;
      end

      ST_ADD_B: begin
        adj_we           = 1'b1;
        adj_waddr        = b_q;
        adj_wdata        = row | (N'(1) << a_q);
        row_vld_d[b_q]   = 1'b1;
        state_d          = ST_IDLE;
      end

      ST_SCAN: begin
        if (found) begin
          // descend: return the pending vertex, push the top, read the new row
          if (out_free) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{visited_vertex: VTX_W'(pend_q), last: 1'b0};
            pend_d      = nxt;
            visited_d   = visited_q | (N'(1) << nxt);
            stk_we      = 1'b1;
            sp_d        = sp_q + SW'(1);
            top_d       = nxt;
            adj_raddr   = nxt;
          end
        end else if (sp_q == '0) begin
          state_d = ST_FLUSH;
        end else begin
          // backtrack: fetch the entry below the top
          sp_d    = sp_q - SW'(1);
          state_d = ST_POP;
        end
      end

      ST_POP: begin
        top_d     = stk_rdata;
        adj_raddr = stk_rdata;
        state_d   = ST_SCAN;
      end

      ST_FLUSH: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{visited_vertex: VTX_W'(pend_q), last: 1'b1};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rd_vld_d = row_vld_d[adj_raddr] & row_vld_q[adj_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= VCOUNT_RST;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      visited_q   <= '0;
      sp_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      row_vld_q   <= row_vld_d;
      rd_vld_q    <= rd_vld_d;
      visited_q   <= visited_d;
      sp_q        <= sp_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    top_q  <= top_d;
    pend_q <= pend_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // the walk stack never holds more than one entry per vertex below the top
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) < N)
    else $error("walk stack overflow");

  // a descent never picks a vertex that is already visited
  a_fresh_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && found) |-> !visited_q[nxt])
    else $error("picked visited vertex");

  // a new response comes only from the walk
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_FLUSH))
    else $error("response outside a walk");

endmodule

// ===== bench/adjacency_matrix_dfs_top_tb.sv =====
`timescale 1ns / 1ps
// testbench for adjacency_matrix_dfs_top: builds graphs, runs depth-first walks and checks
// every visited vertex against its own walk predictor. needs adm_pkg and the block's rtl.
module adjacency_matrix_dfs_top_tb;
  import adm_pkg::*;

  localparam int unsigned MAX_V = 16;
  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // idle cycles allowed after the last response before the block counts as quiet
  localparam int unsigned SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic           req_valid = 1'b0;
  logic           req_stall;
  adm_req_t       req_data = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  adm_rsp_t       rsp_data;
  logic           cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // requests waiting to be offered, and vertices the block still owes us
  adm_req_t req_backlog[$];
  adm_rsp_t expected_visits[$];

  // predictor state: graph rows and the vertex count in use
  logic [MAX_V-1:0] adj_rows [MAX_V] = '{default: '0};
  logic [CFG_W-1:0] vcount_model = VCOUNT_RST;

  // pacing controls, changed only on the falling edge
  bit steady = 1'b0;
  bit hold_rsp = 1'b0;

  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned walks = 0;
  int unsigned vertices_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;

  adjacency_matrix_dfs_top #(
    .MAX_VERTICES(MAX_V)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req_data),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // number of vertices the block really uses: counts above MAX_V saturate
  function automatic int unsigned active_vertices();
    return (vcount_model > MAX_V) ? MAX_V : int'(vcount_model);
  endfunction

  // apply one accepted request to the graph copy and queue the walk it produces
  function automatic void dfs_predict(adm_req_t r);
    int unsigned n;
    int unsigned depth;
    int unsigned nxt;
    logic [MAX_V-1:0] in_use;
    logic [MAX_V-1:0] seen;
    logic [MAX_V-1:0] cand;
    logic [VTX_W-1:0] path [MAX_V];
    logic [VTX_W-1:0] order [$];
    adm_rsp_t rsp;
    n = active_vertices();
    in_use = {MAX_V{1'b1}} >> (MAX_V - n);
    case (r.command)
      CMD_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      CMD_ADD_EDGE: begin
        // edges touching an unused vertex are dropped
        if (r.vertex_a < n && r.vertex_b < n) begin
          adj_rows[r.vertex_a][r.vertex_b] = 1'b1;
          adj_rows[r.vertex_b][r.vertex_a] = 1'b1;
        end
      end
      CMD_VISIT: begin
        if (r.vertex_a < n) begin
          seen = '0;
          seen[r.vertex_a] = 1'b1;
          path[0] = r.vertex_a;
          depth = 1;
          order.push_back(r.vertex_a);
          // explicit path stack, lowest unvisited neighbor first
          while (depth > 0) begin
            cand = adj_rows[path[depth-1]] & in_use & ~seen;
            if (cand == '0) begin
              depth--;
            end else begin
              nxt = 0;
              while (!cand[nxt]) nxt++;
              seen[nxt] = 1'b1;
              path[depth] = VTX_W'(nxt);
              depth++;
              order.push_back(VTX_W'(nxt));
            end
          end
          foreach (order[i]) begin
            rsp.visited_vertex = order[i];
            rsp.last = (i == order.size() - 1);
            expected_visits.push_back(rsp);
          end
          walks++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, adm_rsp_t want, adm_rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected vertex %0d last %0d, got vertex %0d last %0d",
               $time, what, want.visited_vertex, want.last, got.visited_vertex, got.last);
  endtask

  // request driver: predicts on acceptance, holds a stalled request unchanged
  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        dfs_predict(req_data);
        accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
          req_valid <= 1'b1;
          req_data <= req_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: in-order compare, plus random and forced stalls
  always @(posedge clk) begin
    adm_rsp_t want;
    if (!rst_n) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        vertices_checked++;
        if (expected_visits.size() == 0) begin
          flag_mismatch("unexpected response", '0, rsp_data);
        end else begin
          want = expected_visits.pop_front();
          if (rsp_data.visited_vertex !== want.visited_vertex)
            flag_mismatch("visited_vertex", want, rsp_data);
          else if (rsp_data.last !== want.last)
            flag_mismatch("last", want, rsp_data);
        end
      end
      if (hold_rsp)
        rsp_stall <= 1'b1;
      else
        rsp_stall <= !steady && ($urandom_range(99) < 8);
    end
  end

  function automatic void enqueue(logic [1:0] c, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
    adm_req_t r;
    r.command = c;
    r.vertex_a = a;
    r.vertex_b = b;
    req_backlog.push_back(r);
    if (c != CMD_UNUSED) queued++;
  endfunction

  // mostly a vertex in use, sometimes anything the field can carry
  function automatic logic [VTX_W-1:0] pick_vertex();
    int unsigned n;
    n = active_vertices();
    if (n > 0 && $urandom_range(99) < 85)
      return VTX_W'($urandom_range(0, n - 1));
    return VTX_W'($urandom_range(0, 15));
  endfunction

  // wait until nothing is offered or owed, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || expected_visits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only ever called once the block is quiet
  task automatic write_vertex_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount_model = value;
    cfg_writes++;
  endtask

  // one graph build followed by walks; kind 0 sparse, 1 chain with branches,
  // 2 dense, 3 noise
  task automatic queue_graph_phase(int unsigned kind, int unsigned n_visits);
    int unsigned n;
    int unsigned j;
    int unsigned k;
    logic [VTX_W-1:0] perm [MAX_V];
    logic [VTX_W-1:0] t;
    n = active_vertices();
    if (kind != 0 || $urandom_range(1)) enqueue(CMD_CLEAR, pick_vertex(), pick_vertex());
    case (kind)
      0: repeat ($urandom_range(1, 20)) enqueue(CMD_ADD_EDGE, pick_vertex(), pick_vertex());
      1: begin
        // long path through every vertex in use drives the stack to full depth
        for (int i = 0; i < MAX_V; i++) perm[i] = VTX_W'(i);
        for (int i = int'(n) - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = perm[i];
          perm[i] = perm[j];
          perm[j] = t;
        end
        for (int i = 0; i + 1 < int'(n); i++) begin
          if ($urandom_range(1)) enqueue(CMD_ADD_EDGE, perm[i], perm[i+1]);
          else enqueue(CMD_ADD_EDGE, perm[i+1], perm[i]);
        end
        // a few side branches force backtracking
        repeat ($urandom_range(0, 4)) enqueue(CMD_ADD_EDGE, pick_vertex(), pick_vertex());
      end
      2: repeat ($urandom_range(20, 60)) enqueue(CMD_ADD_EDGE, pick_vertex(), pick_vertex());
      default: begin
        repeat ($urandom_range(4, 12)) begin
          k = $urandom_range(0, 3);
          enqueue(2'(k), VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)));
        end
      end
    endcase
    repeat (n_visits) enqueue(CMD_VISIT, pick_vertex(), VTX_W'($urandom_range(0, 15)));
  endtask

  initial begin
    logic [CFG_W-1:0] next_count;
    int unsigned phase;
    bit pressed;
    phase = 0;
    pressed = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count of sixteen: lone vertex, then a small graph with a self loop
    enqueue(CMD_VISIT, 4'd0, 4'd15);
    enqueue(CMD_ADD_EDGE, 4'd0, 4'd15);
    enqueue(CMD_ADD_EDGE, 4'd15, 4'd15);
    enqueue(CMD_ADD_EDGE, 4'd15, 4'd3);
    enqueue(CMD_ADD_EDGE, 4'd2, 4'd1);
    enqueue(CMD_ADD_EDGE, 4'd1, 4'd0);
    enqueue(CMD_VISIT, 4'd15, 4'd0);
    enqueue(CMD_VISIT, 4'd2, 4'd0);
    enqueue(CMD_UNUSED, 4'd15, 4'd15);
    enqueue(CMD_CLEAR, 4'd15, 4'd15);
    enqueue(CMD_VISIT, 4'd15, 4'd0);
    drain();
    // zero vertices in use: edge dropped, walk silent
    write_vertex_count(5'd0);
    @(negedge clk);
    enqueue(CMD_ADD_EDGE, 4'd0, 4'd1);
    enqueue(CMD_VISIT, 4'd0, 4'd0);
    drain();
    // count beyond the limit saturates at sixteen
    write_vertex_count(5'd31);
    @(negedge clk);
    enqueue(CMD_ADD_EDGE, 4'd14, 4'd15);
    enqueue(CMD_ADD_EDGE, 4'd3, 4'd15);
    enqueue(CMD_ADD_EDGE, 4'd0, 4'd3);
    enqueue(CMD_VISIT, 4'd14, 4'd0);
    drain();
    // shrunk count: out-of-range endpoint and start, stored edge to 15 ignored
    write_vertex_count(5'd4);
    @(negedge clk);
    enqueue(CMD_ADD_EDGE, 4'd3, 4'd5);
    enqueue(CMD_VISIT, 4'd5, 4'd0);
    enqueue(CMD_VISIT, 4'd3, 4'd0);
    enqueue(CMD_VISIT, 4'd0, 4'd0);
    drain();
    // single vertex with a self loop
    write_vertex_count(5'd1);
    @(negedge clk);
    enqueue(CMD_ADD_EDGE, 4'd0, 4'd0);
    enqueue(CMD_VISIT, 4'd0, 4'd0);
    drain();
    write_vertex_count(5'd16);

    // random part: graph phases with walks, count changed between phases
    while (queued < 440) begin
      @(negedge clk);
      // a stretch of phases with no idling on either side
      steady = (phase >= 4 && phase < 9);
      if (!pressed && queued > 220) begin
        // receiver holds off while the sender keeps offering long walks
        drain();
        write_vertex_count(5'd16);
        @(negedge clk);
        steady = 1'b0;
        queue_graph_phase(1, 12);
        hold_rsp = 1'b1;
        repeat (400) @(negedge clk);
        hold_rsp = 1'b0;
        pressed = 1'b1;
        drain();
      end else begin
        queue_graph_phase($urandom_range(99) < 10 ? 3 : $urandom_range(0, 2),
                          $urandom_range(2, 6));
        do @(negedge clk); while (req_backlog.size() != 0);
      end
      phase++;
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: next_count = 5'd0;
          1: next_count = CFG_W'($urandom_range(17, 31));
          2, 3: next_count = CFG_W'($urandom_range(1, 15));
          default: next_count = 5'd16;
        endcase
        drain();
        write_vertex_count(next_count);
      end
    end
    drain();

    $display("ran %0d requests including %0d walks, %0d vertices checked",
             accepted, walks, vertices_checked);
    $display("graph phases: %0d, vertex count writes: %0d, mismatches: %0d",
             phase, cfg_writes, mismatches);
    if (mismatches == 0 && expected_visits.size() == 0) begin
      $display("adjacency_matrix_dfs_top_tb: PASS");
    end else begin
      $display("adjacency_matrix_dfs_top_tb: FAIL");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5000000;
    $display("timeout with %0d responses still owed", expected_visits.size());
    $display("adjacency_matrix_dfs_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/adm_pkg.sv
src/adm_ram.sv
src/adm_pri_enc.sv
src/adjacency_matrix_dfs_top.sv
bench/adjacency_matrix_dfs_top_tb.sv
